>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when NO_ASSERTIONS is set
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define ASSERT_HOLD(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_HOLD(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, expr)

`endif

`endif

>>> hdl/hct_pkg.sv
// ---------------------------------------------------------------------------
// hct_pkg
// Shared types, constants and mod-26 helpers for the trigram cipher block
// ---------------------------------------------------------------------------
package hct_pkg;

  localparam int unsigned MODULUS   = 26;
  // 2^16 / 26 rounded up, exact floor quotient for values below 2048
  localparam int unsigned RECIP_26  = 2521;
  // 26 * 25, keeps a difference of two products non-negative
  localparam int unsigned MOD_BIAS  = 650;
  localparam int unsigned LETTER_W  = 5;
  localparam int unsigned KEY_W     = 45;
  localparam int unsigned KEY_N     = 9;
  localparam int unsigned SETTLE    = 3;
  // result queue depth
  localparam int unsigned OUT_DEPTH = 4;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_KEY  = 1'b0,
    CFG_MODE = 1'b1
  } hct_cfg_e;

  typedef logic [LETTER_W-1:0] hct_letter_t;

  typedef struct packed {
    hct_letter_t letter_third;
    hct_letter_t letter_second;
    hct_letter_t letter_first;
  } hct_in_t;

  typedef struct packed {
    logic        key_error;
    hct_letter_t out_third;
    hct_letter_t out_second;
    hct_letter_t out_first;
  } hct_out_t;

  // reduced trigram, entry 0 is the first letter
  typedef hct_letter_t [2:0] hct_trig_t;

  // effective 3x3 matrix, row-major, plus the error flag
  typedef struct packed {
    hct_letter_t [KEY_N-1:0] m;
    logic                    err;
  } hct_mat_t;

  // reduce a 5-bit value into 0..25
  function automatic hct_letter_t red26(input hct_letter_t x);
    return (x >= hct_letter_t'(MODULUS)) ? x - hct_letter_t'(MODULUS) : x;
  endfunction

  // x mod 26 for x below 2048, reciprocal multiply and one correction
  function automatic hct_letter_t mod26(input logic [10:0] x);
    logic [23:0] prod;
    logic [6:0]  quo;
    logic [11:0] rem;
    prod = 24'(x) * 24'(RECIP_26);
    quo  = prod[22:16];
    rem  = 12'(x) - 12'(quo) * 12'(MODULUS);
    if (rem >= 12'(MODULUS)) begin
      rem = rem - 12'(MODULUS);
    end
    return rem[4:0];
  endfunction

  // inverse modulo 26, zero when none exists
  function automatic hct_letter_t inv26(input hct_letter_t d);
    hct_letter_t r;
    case (d)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // (p*q - r*s) mod 26 for operands in 0..25
  function automatic hct_letter_t cross26(input hct_letter_t p, input hct_letter_t q,
                                          input hct_letter_t r, input hct_letter_t s);
    logic [9:0] a;
    logic [9:0] b;
    a = 10'(p) * 10'(q);
    b = 10'(r) * 10'(s);
    return mod26(11'(a) + 11'(MOD_BIAS) - 11'(b));
  endfunction

endpackage

>>> hdl/hill_cipher_trigram.sv
// An accepted trigram waits in the input queue, is registered as row sums and is then written to the result queue.
// Throughput: one trigram per cycle when results are popped as they appear.
// After reset and after any register write, full stays high while the
// three-stage key derivation pipeline refills.
// Reset clears the key and mode registers to zero and empties both queues.
// ---------------------------------------------------------------------------
// hill_cipher_trigram
// Hill cipher on three-letter blocks modulo 26, encrypt or decrypt
// ---------------------------------------------------------------------------
module hill_cipher_trigram (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [hct_pkg::KEY_W-1:0] cfg_data_i,
  input  logic                      push,
  output logic                      full,
  input  hct_pkg::hct_in_t          in_data_i,
  output logic                      empty,
  input  logic                      pop,
  output hct_pkg::hct_out_t         out_data_o
);
  import hct_pkg::*;

  hct_mat_t  mat;
  logic      busy;
  logic      f_valid;
  logic      take;
  hct_trig_t trig;

  // configuration and key matrix
  hct_key u_key (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .mat_o      (mat),
    .busy_o     (busy)
  );

  // input queue
  hct_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .in_data_i (in_data_i),
    .busy_i    (busy),
    .take_i    (take),
    .valid_o   (f_valid),
    .trig_o    (trig)
  );

  // product pipeline and result queue
  hct_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (f_valid),
    .trig_i     (trig),
    .mat_i      (mat),
    .take_o     (take),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_data_o (out_data_o)
  );

endmodule

>>> hdl/hct_key.sv
// ---------------------------------------------------------------------------
// hct_key
// Configuration registers and the key derivation pipeline: reduced key,
// adjugate, determinant and modular inverse matrix
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hct_key (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [hct_pkg::KEY_W-1:0] cfg_data_i,
  output hct_pkg::hct_mat_t        mat_o,
  output logic                     busy_o
);
  import hct_pkg::*;

  logic [KEY_W-1:0] key_q, key_d;
  logic             mode_q, mode_d;
  logic [1:0]       settle_q, settle_d;

  hct_letter_t [KEY_N-1:0] k1_q, k1_d, adj1_q, adj1_d;
  logic                    mode1_q;
  hct_letter_t [KEY_N-1:0] k2_q, adj2_q;
  hct_letter_t             det2_q, det2_d;
  logic                    mode2_q;
  hct_mat_t                mat_q, mat_d;

  // register writes
  always_comb begin
    key_d  = key_q;
    mode_d = mode_q;
    if (cfg_we_i) begin
      case (hct_cfg_e'(cfg_idx_i))
        CFG_KEY:  key_d  = cfg_data_i;
        CFG_MODE: mode_d = cfg_data_i[0];
        default:  key_d  = key_q;
      endcase
    end
  end

  // settle count keeps the input closed until the matrix is current
  always_comb begin
    settle_d = settle_q;
    if (cfg_we_i) begin
      settle_d = 2'(SETTLE);
    end else if (settle_q != 2'd0) begin
      settle_d = settle_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q    <= '0;
      mode_q   <= 1'b0;
      settle_q <= 2'(SETTLE);
    end else begin
      key_q    <= key_d;
      mode_q   <= mode_d;
      settle_q <= settle_d;
    end
  end

  // stage 1: reduced key and adjugate
  always_comb begin
    for (int i = 0; i < KEY_N; i++) begin
      k1_d[i] = red26(key_q[i*LETTER_W +: LETTER_W]);
    end
    adj1_d[0] = cross26(k1_d[4], k1_d[8], k1_d[5], k1_d[7]);
    adj1_d[1] = cross26(k1_d[2], k1_d[7], k1_d[1], k1_d[8]);
    adj1_d[2] = cross26(k1_d[1], k1_d[5], k1_d[2], k1_d[4]);
    adj1_d[3] = cross26(k1_d[5], k1_d[6], k1_d[3], k1_d[8]);
    adj1_d[4] = cross26(k1_d[0], k1_d[8], k1_d[2], k1_d[6]);
    adj1_d[5] = cross26(k1_d[2], k1_d[3], k1_d[0], k1_d[5]);
    adj1_d[6] = cross26(k1_d[3], k1_d[7], k1_d[4], k1_d[6]);
    adj1_d[7] = cross26(k1_d[1], k1_d[6], k1_d[0], k1_d[7]);
    adj1_d[8] = cross26(k1_d[0], k1_d[4], k1_d[1], k1_d[3]);
  end

  // stage 2: determinant from the first row and first adjugate column
  always_comb begin
    det2_d = mod26(11'(10'(k1_q[0]) * 10'(adj1_q[0]))
                 + 11'(10'(k1_q[1]) * 10'(adj1_q[3]))
                 + 11'(10'(k1_q[2]) * 10'(adj1_q[6])));
  end

  // stage 3: select key or scaled adjugate
  always_comb begin
    hct_letter_t inv;
    inv       = inv26(det2_q);
    mat_d.err = mode2_q && (inv == '0);
    for (int i = 0; i < KEY_N; i++) begin
      if (!mode2_q) begin
        mat_d.m[i] = k2_q[i];
      end else if (mat_d.err) begin
        mat_d.m[i] = '0;
      end else begin
        mat_d.m[i] = mod26(11'(10'(adj2_q[i]) * 10'(inv)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k1_q    <= k1_d;
    adj1_q  <= adj1_d;
    mode1_q <= mode_q;
    k2_q    <= k1_q;
    adj2_q  <= adj1_q;
    det2_q  <= det2_d;
    mode2_q <= mode1_q;
    mat_q   <= mat_d;
  end

  assign mat_o  = mat_q;
  assign busy_o = (settle_q != 2'd0);

  // a register write closes the input on the next cycle
  `ASSERT_HOLD(a_write_closes, clk_i, rst_ni, cfg_we_i |=> busy_o)
  // in decrypt mode, a non-invertible key carries an all-zero matrix
  `ASSERT_HOLD(a_err_zero, clk_i, rst_ni, (!busy_o && mat_q.err) |-> (mat_q.m == '0))

endmodule

>>> hdl/hct_front.sv
// ---------------------------------------------------------------------------
// hct_front
// Input side: accepts trigrams, reduces letters into 0..25 and holds them
// in a two-entry queue for the multiply pipeline
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hct_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  hct_pkg::hct_in_t  in_data_i,
  input  logic              busy_i,
  input  logic              take_i,
  output logic              valid_o,
  output hct_pkg::hct_trig_t trig_o
);
  import hct_pkg::*;

  hct_trig_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_en, rd_en;

  assign full_o  = (cnt_q == 2'd2) || busy_i;
  assign valid_o = (cnt_q != 2'd0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = take_i && valid_o;
  assign trig_o  = mem_q[rd_ptr_q];

  // queue pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ wr_en;
    rd_ptr_d = rd_ptr_q ^ rd_en;
    cnt_d    = cnt_q + 2'(wr_en) - 2'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // store reduced letters of an accepted transaction
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= {red26(in_data_i.letter_third),
                          red26(in_data_i.letter_second),
                          red26(in_data_i.letter_first)};
    end
  end

  `ASSERT_NEVER(a_front_overflow, clk_i, rst_ni, cnt_q > 2'd2)

endmodule

>>> hdl/hct_back.sv
// ---------------------------------------------------------------------------
// hct_back
// Matrix-vector product modulo 26 and the result queue
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hct_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  hct_pkg::hct_trig_t trig_i,
  input  hct_pkg::hct_mat_t  mat_i,
  output logic               take_o,
  input  logic               pop_i,
  output logic               empty_o,
  output hct_pkg::hct_out_t  out_data_o
);
  import hct_pkg::*;

  logic [10:0] sum_q [3];
  logic [10:0] sum_d [3];
  logic        err_q;
  logic        s1_v_q;

  hct_out_t    mem_q [OUT_DEPTH];
  hct_out_t    res;
  logic [1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        rd_en;

  // take a trigram only while the result queue has room for it
  assign take_o = valid_i && ((cnt_q + 3'(s1_v_q)) < 3'(OUT_DEPTH));

  // stage 1: row sums of products
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_d[r] = 11'(10'(mat_i.m[3*r])   * 10'(trig_i[0]))
               + 11'(10'(mat_i.m[3*r+1]) * 10'(trig_i[1]))
               + 11'(10'(mat_i.m[3*r+2]) * 10'(trig_i[2]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      sum_q <= sum_d;
      err_q <= mat_i.err;
    end
  end

  // stage 2: reduce into letters
  always_comb begin
    res.key_error  = err_q;
    res.out_first  = err_q ? '0 : mod26(sum_q[0]);
    res.out_second = err_q ? '0 : mod26(sum_q[1]);
    res.out_third  = err_q ? '0 : mod26(sum_q[2]);
  end

  // result queue control
  assign empty_o    = (cnt_q == 3'd0);
  assign rd_en      = pop_i && !empty_o;
  assign out_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + 2'(s1_v_q);
    rd_ptr_d = rd_ptr_q + 2'(rd_en);
    cnt_d    = cnt_q + 3'(s1_v_q) - 3'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      s1_v_q   <= take_o;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      mem_q[wr_ptr_q] <= res;
    end
  end

  // the credit check keeps the queue from overflowing
  `ASSERT_NEVER(a_out_overflow, clk_i, rst_ni, cnt_q > 3'(OUT_DEPTH))
  // an error result carries zero first and third letters
  `ASSERT_HOLD(a_err_letters, clk_i, rst_ni,
               (s1_v_q && err_q) |-> (res.out_first == '0 && res.out_third == '0))

endmodule

>>> dv/hct_cipher_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hct_cipher_checker
// Watches the trigram and result queues of the cipher block, works out each
// result from its own copy of key and mode, and compares field by field
// ---------------------------------------------------------------------------
module hct_cipher_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [hct_pkg::KEY_W-1:0] cfg_data_i,
  input  logic                      push_i,
  input  logic                      full_i,
  input  hct_pkg::hct_in_t          in_data_i,
  input  logic                      empty_i,
  input  logic                      pop_i,
  input  hct_pkg::hct_out_t         out_data_i,
  output int                        mismatches_o,
  output int                        pending_o
);
  import hct_pkg::*;

  localparam int ALPHABET     = MODULUS;
  localparam int REPORT_LIMIT = 40;

  // shadow of the block's registers
  logic [KEY_W-1:0] cipher_key;
  logic             cipher_decrypt;

  // results still owed by the block, oldest first
  hct_out_t expected_results[$];
  hct_out_t oldest;
  int       mismatch_count = 0;

  // reduce any integer into 0..25
  function automatic int wrap26(input int x);
    return ((x % ALPHABET) + ALPHABET) % ALPHABET;
  endfunction

  // letters of one trigram after the key (or its inverse) is applied
  function automatic hct_out_t hill_transform(input logic [KEY_W-1:0] key,
                                              input logic decrypt,
                                              input hct_in_t trigram);
    int       k[9];
    int       adj[9];
    int       m[9];
    int       v[3];
    int       det;
    int       inv;
    int       i;
    hct_out_t r;
    for (i = 0; i < 9; i++) begin
      k[i] = int'(key[LETTER_W*i +: LETTER_W]) % ALPHABET;
    end
    v[0] = int'(trigram.letter_first) % ALPHABET;
    v[1] = int'(trigram.letter_second) % ALPHABET;
    v[2] = int'(trigram.letter_third) % ALPHABET;
    r = '0;
    if (!decrypt) begin
      m = k;
    end else begin
      // adjugate, row-major
      adj[0] = k[4] * k[8] - k[5] * k[7];
      adj[1] = k[2] * k[7] - k[1] * k[8];
      adj[2] = k[1] * k[5] - k[2] * k[4];
      adj[3] = k[5] * k[6] - k[3] * k[8];
      adj[4] = k[0] * k[8] - k[2] * k[6];
      adj[5] = k[2] * k[3] - k[0] * k[5];
      adj[6] = k[3] * k[7] - k[4] * k[6];
      adj[7] = k[1] * k[6] - k[0] * k[7];
      adj[8] = k[0] * k[4] - k[1] * k[3];
      det = wrap26(k[0] * adj[0] + k[1] * adj[3] + k[2] * adj[6]);
      // search the inverse of the determinant
      inv = 0;
      for (i = 1; i < ALPHABET && inv == 0; i++) begin
        if ((det * i) % ALPHABET == 1) inv = i;
      end
      // no inverse: error flag, letters stay zero
      if (inv == 0) begin
        r.key_error = 1'b1;
        return r;
      end
      for (i = 0; i < 9; i++) begin
        m[i] = wrap26(adj[i] * inv);
      end
    end
    r.out_first  = hct_letter_t'(wrap26(m[0] * v[0] + m[1] * v[1] + m[2] * v[2]));
    r.out_second = hct_letter_t'(wrap26(m[3] * v[0] + m[4] * v[1] + m[5] * v[2]));
    r.out_third  = hct_letter_t'(wrap26(m[6] * v[0] + m[7] * v[1] + m[8] * v[2]));
    return r;
  endfunction

  // one field of a result transaction
  task automatic check_field(input string field, input logic [LETTER_W-1:0] want,
                             input logic [LETTER_W-1:0] got);
    if (got !== want) begin
      if (mismatch_count < REPORT_LIMIT) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
      mismatch_count++;
    end
  endtask

  // track registers, predict on each trigram, compare on each result
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_results.delete();
      cipher_key     = '0;
      cipher_decrypt = 1'b0;
      pending_o     <= 0;
      mismatches_o  <= mismatch_count;
    end else begin
      // result transaction against the oldest prediction
      if (pop_i && !empty_i) begin
        if (expected_results.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT) begin
            $display("%0t: result with none expected, expected nothing, actual %p",
                     $time, out_data_i);
          end
          mismatch_count++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("out_first", oldest.out_first, out_data_i.out_first);
          check_field("out_second", oldest.out_second, out_data_i.out_second);
          check_field("out_third", oldest.out_third, out_data_i.out_third);
          check_field("key_error", LETTER_W'(oldest.key_error),
                      LETTER_W'(out_data_i.key_error));
        end
      end
      // trigram transaction
      if (push_i && !full_i) begin
        expected_results = {expected_results,
                            hill_transform(cipher_key, cipher_decrypt, in_data_i)};
      end
      // register writes
      if (cfg_we_i) begin
        case (hct_cfg_e'(cfg_idx_i))
          CFG_KEY:  cipher_key = cfg_data_i;
          CFG_MODE: cipher_decrypt = cfg_data_i[0];
          default:  ;
        endcase
      end
      pending_o    <= expected_results.size();
      mismatches_o <= mismatch_count;
    end
  end

endmodule

>>> dv/hill_cipher_trigram_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hill_cipher_trigram_tb
// Drives trigrams through the cipher under a series of keys and modes,
// with bursty input and a stalling result side; the checker predicts and
// compares every result
// ---------------------------------------------------------------------------
module hill_cipher_trigram_tb;
  import hct_pkg::*;

  localparam int ALPHABET       = MODULUS;
  localparam int RANDOM_ITEMS   = 1100;
  localparam int WATCHDOG_LIMIT = 1000;

  // keys used by the directed part
  localparam logic [KEY_W-1:0] KEY_CLASSIC =
    {5'd15, 5'd17, 5'd20, 5'd10, 5'd16, 5'd13, 5'd1, 5'd24, 5'd6};
  localparam logic [KEY_W-1:0] KEY_DET13 =
    {5'd1, 5'd0, 5'd0, 5'd0, 5'd1, 5'd0, 5'd0, 5'd0, 5'd13};
  localparam logic [KEY_W-1:0] KEY_WRAPPED_IDENTITY =
    {5'd27, 5'd26, 5'd26, 5'd26, 5'd27, 5'd26, 5'd26, 5'd26, 5'd27};
  localparam logic [KEY_W-1:0] KEY_ALL_ONES = {KEY_W{1'b1}};

  typedef enum int {
    POP_ALWAYS,
    POP_LIGHT,
    POP_HEAVY,
    POP_PERIODIC
  } pop_style_e;

  logic             clk_i      = 1'b0;
  logic             rst_ni     = 1'b0;
  logic             cfg_we_i   = 1'b0;
  logic             cfg_idx_i  = 1'b0;
  logic [KEY_W-1:0] cfg_data_i = '0;
  logic             push       = 1'b0;
  logic             full;
  hct_in_t          in_data_i  = '0;
  logic             empty;
  logic             pop        = 1'b0;
  hct_out_t         out_data_o;

  int         check_failures;
  int         results_owed;
  int         burst_left  = 0;
  int         style_left  = 0;
  pop_style_e pop_style   = POP_ALWAYS;
  int         idle_cycles = 0;

  hill_cipher_trigram i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .push      (push),
    .full      (full),
    .in_data_i (in_data_i),
    .empty     (empty),
    .pop       (pop),
    .out_data_o(out_data_o)
  );

  hct_cipher_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .full_i      (full),
    .in_data_i   (in_data_i),
    .empty_i     (empty),
    .pop_i       (pop),
    .out_data_i  (out_data_o),
    .mismatches_o(check_failures),
    .pending_o   (results_owed)
  );

  // clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // mostly plain letters, now and then one of the wrapped codes 26..31
  function automatic hct_letter_t pick_letter();
    if ($urandom_range(0, 7) == 0) return hct_letter_t'($urandom_range(26, 31));
    return hct_letter_t'($urandom_range(0, 25));
  endfunction

  // determinant is a unit modulo 26
  function automatic logic key_is_invertible(input logic [KEY_W-1:0] key);
    int e[9];
    int det;
    int i;
    for (i = 0; i < 9; i++) begin
      e[i] = int'(key[LETTER_W*i +: LETTER_W]);
    end
    det = e[0] * (e[4] * e[8] - e[5] * e[7]) - e[1] * (e[3] * e[8] - e[5] * e[6])
        + e[2] * (e[3] * e[7] - e[4] * e[6]);
    det = ((det % ALPHABET) + ALPHABET) % ALPHABET;
    return (det % 2 == 1) && (det != 13);
  endfunction

  // random key; decrypt phases lean toward keys that have an inverse
  function automatic logic [KEY_W-1:0] pick_key(input logic decrypt);
    logic [KEY_W-1:0] key;
    logic             want_unit;
    int               i;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return KEY_ALL_ONES;
      default: ;
    endcase
    want_unit = decrypt && ($urandom_range(0, 3) != 0);
    do begin
      for (i = 0; i < KEY_N; i++) begin
        key[LETTER_W*i +: LETTER_W] = pick_letter();
      end
    end while (want_unit && !key_is_invertible(key));
    return key;
  endfunction

  // one trigram transaction, with bursts and gaps in between
  task automatic send_trigram(input hct_letter_t first, input hct_letter_t second,
                              input hct_letter_t third);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 16);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    push      <= 1'b1;
    in_data_i <= {third, second, first};
    do @(posedge clk_i); while (full);
  endtask

  // stop sending and wait until every result has come back
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk_i);
    while (results_owed != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input hct_cfg_e idx, input logic [KEY_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_cipher(input logic [KEY_W-1:0] key, input logic decrypt);
    drain_results();
    write_reg(CFG_KEY, key);
    write_reg(CFG_MODE, KEY_W'(decrypt));
  endtask

  // result side stalls in styles that are picked anew at random
  always @(posedge clk_i) begin
    if (style_left == 0) begin
      style_left = $urandom_range(16, 96);
      pop_style  = pop_style_e'($urandom_range(0, 3));
    end
    style_left--;
    case (pop_style)
      POP_ALWAYS: pop <= 1'b1;
      POP_LIGHT:  pop <= ($urandom_range(0, 3) != 0);
      POP_HEAVY:  pop <= ($urandom_range(0, 3) == 0);
      default:    pop <= ((style_left % 8) < 5);
    endcase
  end

  // watchdog on cycles with no transaction of any kind
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  initial begin
    int               random_sent;
    int               phase_items;
    logic [KEY_W-1:0] key;
    logic             decrypt;
    random_sent = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset values: zero key, encrypt
    send_trigram(5'd0, 5'd0, 5'd0);
    send_trigram(5'd25, 5'd25, 5'd25);
    send_trigram(5'd31, 5'd26, 5'd13);

    // invertible key, encrypt: extremes, unit vectors, wrapped letters
    set_cipher(KEY_CLASSIC, 1'b0);
    send_trigram(5'd0, 5'd0, 5'd0);
    send_trigram(5'd25, 5'd25, 5'd25);
    send_trigram(5'd1, 5'd0, 5'd0);
    send_trigram(5'd0, 5'd1, 5'd0);
    send_trigram(5'd0, 5'd0, 5'd1);
    send_trigram(5'd26, 5'd27, 5'd28);
    send_trigram(5'd29, 5'd30, 5'd31);
    send_trigram(5'd7, 5'd19, 5'd2);

    // same key, decrypt
    set_cipher(KEY_CLASSIC, 1'b1);
    send_trigram(5'd25, 5'd25, 5'd25);
    send_trigram(5'd0, 5'd1, 5'd0);
    send_trigram(5'd31, 5'd30, 5'd29);
    send_trigram(5'd19, 5'd4, 5'd11);

    // singular key with all bits set: error on decrypt, none on encrypt
    set_cipher(KEY_ALL_ONES, 1'b1);
    send_trigram(5'd3, 5'd4, 5'd5);
    send_trigram(5'd31, 5'd31, 5'd31);
    set_cipher(KEY_ALL_ONES, 1'b0);
    send_trigram(5'd3, 5'd4, 5'd5);

    // determinant 13 shares a factor with 26
    set_cipher(KEY_DET13, 1'b1);
    send_trigram(5'd1, 5'd2, 5'd3);

    // key entries 26 and 27 wrap to an identity
    set_cipher(KEY_WRAPPED_IDENTITY, 1'b1);
    send_trigram(5'd5, 5'd26, 5'd31);
    set_cipher(KEY_WRAPPED_IDENTITY, 1'b0);
    send_trigram(5'd5, 5'd26, 5'd31);

    // random keys, modes and trigrams
    while (random_sent < RANDOM_ITEMS) begin
      decrypt = 1'($urandom_range(0, 1));
      key     = pick_key(decrypt);
      set_cipher(key, decrypt);
      phase_items = $urandom_range(20, 90);
      repeat (phase_items) send_trigram(pick_letter(), pick_letter(), pick_letter());
      random_sent += phase_items;
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (check_failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/hct_pkg.sv
hdl/hct_key.sv
hdl/hct_front.sv
hdl/hct_back.sv
hdl/hill_cipher_trigram.sv
dv/hct_cipher_checker.sv
dv/hill_cipher_trigram_tb.sv
